/* rtl/amcd_pkg.sv */
`timescale 1ns / 1ps

package amcd_pkg;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_SKIP    = 2'd2,
      PH_PAD     = 2'd3
   } amcd_phase_type;

   typedef enum logic [1:0] {
      CSR_MOVI_LENGTH     = 2'd0,
      CSR_MAX_VIDEO_BYTES = 2'd1,
      CSR_AUDIO_ENABLED   = 2'd2
   } amcd_csr_index_type;

   localparam logic [31:0] FCC_VIDEO = 32'h6364_3030;
   localparam logic [31:0] FCC_AUDIO = 32'h6277_3130;
   localparam logic [31:0] FCC_LIST  = 32'h5453_494C;

   localparam logic [31:0] MAX_VIDEO_RESET = 32'd65536;
   localparam logic [31:0] LIST_TYPE_BYTES = 32'd4;

   localparam logic KIND_VIDEO = 1'b0;
   localparam logic KIND_AUDIO = 1'b1;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [31:0] movi_length;
      logic [31:0] max_video_bytes;
      logic        audio_enabled;
   } amcd_cfg_type;

   typedef struct packed {
      logic [31:0] frame_number;
      logic        chunk_last;
      logic        stream_kind;
      logic [7:0]  payload_byte;
   } amcd_result_type;

endpackage

/* rtl/amcd_parser.sv */
`timescale 1ns / 1ps

module amcd_parser
   import amcd_pkg::*;
#(
   parameter int POSITION_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            byte_valid,
   input  logic [7:0]      byte_data,
   input  amcd_cfg_type    cfg,
   output logic            result_push,
   output amcd_result_type result
);

   amcd_phase_type phase_ff, phase_in;
   logic [55:0] header_ff, header_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] remaining_ff, remaining_in;
   logic        pad_ff, pad_in;
   logic        kind_ff, kind_in;
   logic [POSITION_WIDTH-1:0] position_ff, position_in;
   logic [31:0] frame_ff, frame_in;

   logic [31:0] tag;
   logic [31:0] size;
   logic        is_video, is_audio, is_list, take;
   logic        header_done, rem_one, rem_low;
   logic [POSITION_WIDTH-1:0] position_next;
   logic        wrap;
   amcd_phase_type after_body;

   assign tag           = header_ff[31:0];
   assign size          = {byte_data, header_ff[55:32]};
   assign is_video      = (tag == FCC_VIDEO);
   assign is_audio      = (tag == FCC_AUDIO);
   assign is_list       = (tag == FCC_LIST);
   assign take          = (is_video && size != 32'd0 && size <= cfg.max_video_bytes)
                       || (is_audio && cfg.audio_enabled && size != 32'd0);
   assign header_done   = (count_ff == 3'd7);
   assign rem_one       = (remaining_ff == 32'd1);
   assign rem_low       = (remaining_ff <= 32'd1);
   assign after_body    = pad_ff ? PH_PAD : PH_HEADER;
   assign position_next = position_ff + 1'b1;
   assign wrap          = (cfg.movi_length != 32'd0)
                       && (32'(position_next) >= cfg.movi_length);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (header_done) begin
                  if (is_list) begin
                     phase_in = PH_SKIP;
                  end else if (take) begin
                     phase_in = PH_PAYLOAD;
                  end else if (size != 32'd0) begin
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_HEADER;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (rem_one) begin
                  phase_in = after_body;
               end
            end
            PH_SKIP: begin
               if (rem_low) begin
                  phase_in = after_body;
               end
            end
            PH_PAD: begin
               phase_in = PH_HEADER;
            end
         endcase
         if (wrap) begin
            phase_in = PH_HEADER;
         end
      end
   end

   // datapath and results
   always_comb begin
      header_in    = header_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      pad_in       = pad_ff;
      kind_in      = kind_ff;
      position_in  = position_ff;
      frame_in     = frame_ff;
      result_push  = 1'b0;
      result.payload_byte = byte_data;
      result.stream_kind  = kind_ff;
      result.chunk_last   = rem_one;
      result.frame_number = frame_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (header_done) begin
                  count_in  = 3'd0;
                  header_in = '0;
                  if (is_video) begin
                     kind_in = KIND_VIDEO;
                  end else if (is_audio) begin
                     kind_in = KIND_AUDIO;
                  end
                  if (is_list) begin
                     remaining_in = LIST_TYPE_BYTES;
                     pad_in       = 1'b0;
                  end else begin
                     remaining_in = size;
                     pad_in       = size[0];
                  end
               end else begin
                  header_in[count_ff*8 +: 8] = byte_data;
                  count_in = count_ff + 3'd1;
               end
            end
            PH_PAYLOAD: begin
               result_push  = 1'b1;
               remaining_in = remaining_ff - 32'd1;
               if (rem_one && kind_ff == KIND_VIDEO) begin
                  frame_in = frame_ff + 32'd1;
               end
            end
            PH_SKIP: begin
               if (remaining_ff != 32'd0) begin
                  remaining_in = remaining_ff - 32'd1;
               end
            end
            PH_PAD: begin
               pad_in = 1'b0;
            end
         endcase
         position_in = position_next;
         if (wrap) begin
            position_in  = '0;
            frame_in     = '0;
            header_in    = '0;
            count_in     = '0;
            remaining_in = '0;
            pad_in       = 1'b0;
            kind_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         header_ff    <= '0;
         count_ff     <= '0;
         remaining_ff <= '0;
         pad_ff       <= 1'b0;
         kind_ff      <= 1'b0;
         position_ff  <= '0;
         frame_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         pad_ff       <= pad_in;
         kind_ff      <= kind_in;
         position_ff  <= position_in;
         frame_ff     <= frame_in;
      end
   end

endmodule

/* rtl/amcd_queue.sv */
`timescale 1ns / 1ps

module amcd_queue
   import amcd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  amcd_result_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output amcd_result_type head_data
);

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   amcd_result_type slot_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic do_pop;

   assign full       = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/avi_movi_chunk_demux.sv */
`timescale 1ns / 1ps
// a payload byte transferred on req is written into the result queue and shows on rsp
// throughput: one byte per cycle; req_tready drops only while the two-entry
// result queue between parser and output holds two results
// reset: synchronous, active high; clears parser state, queue and sets the
// registers to movi_length 0, max_video_bytes 65536, audio_enabled 0

module avi_movi_chunk_demux
   import amcd_pkg::*;
#(
   parameter int POSITION_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // payload_byte, frame_number
   output logic        rsp_tlast,    // chunk_last
   output logic        rsp_tuser,    // stream_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   amcd_cfg_type    cfg_ff, cfg_in;
   amcd_result_type result, head;
   logic            result_push, queue_full, accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MOVI_LENGTH:     cfg_in.movi_length     = csr_data;
            CSR_MAX_VIDEO_BYTES: cfg_in.max_video_bytes = csr_data;
            CSR_AUDIO_ENABLED:   cfg_in.audio_enabled   = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.movi_length     <= '0;
         cfg_ff.max_video_bytes <= MAX_VIDEO_RESET;
         cfg_ff.audio_enabled   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   amcd_parser #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .byte_data  (req_tdata),
      .cfg        (cfg_ff),
      .result_push(result_push),
      .result     (result)
   );

   amcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .full      (queue_full),
      .pop       (rsp_tready),
      .head_valid(rsp_tvalid),
      .head_data (head)
   );

   assign rsp_tdata = {head.frame_number, head.payload_byte};
   assign rsp_tlast = head.chunk_last;
   assign rsp_tuser = head.stream_kind;

endmodule

/* rtl/amcd_checker.sv */
`timescale 1ns / 1ps

module amcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // no result left over from before reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a result only appears after an input transfer
   a_rise_needs_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result appeared without an input transfer");

   // input is only held off while results are waiting
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no pending result");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind avi_movi_chunk_demux amcd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast),
   .rsp_tuser (rsp_tuser)
);
